// ===== src/chp_pkg.sv =====
// Shared constants, codes and types of the CPU hotplug policy block.
`default_nettype none
package chp_pkg;

    // CPU counts
    localparam int unsigned NUM_CPUS      = 8;
    localparam int unsigned BOOT_MIN_CPUS = 4;
    localparam int unsigned HALF_CPUS     = NUM_CPUS / 2;

    // Field widths
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned FREQ_W     = 22;
    localparam int unsigned UTIL_W     = 10;
    localparam int unsigned RUNQ_W     = 16;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned STREAK_W   = 8;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 22;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUSPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESUME  = 2'd2;

    // Result actions
    localparam logic [ACT_W-1:0] ACT_STAY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DOWN = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FREQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD      = 2'd2;

    // Register reset values
    localparam logic [FREQ_W-1:0] UP_FREQ_RST   = 22'd1300000;
    localparam logic [FREQ_W-1:0] DOWN_FREQ_RST = 22'd1500000;
    localparam logic [UTIL_W-1:0] LOAD_RST      = 10'd320;

    // Policy constants
    localparam logic [RUNQ_W-1:0]   TASK_LIMIT   = 16'd410;
    localparam logic [STREAK_W-1:0] UP_PERSIST   = 8'd1;
    localparam logic [STREAK_W-1:0] DOWN_PERSIST = 8'd3;
    localparam logic [STREAK_W-1:0] STREAK_MAX   = 8'd255;

    // One accepted input word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FREQ_W-1:0] freq_a;
        logic [FREQ_W-1:0] freq_b;
        logic [UTIL_W-1:0] util_a;
        logic [UTIL_W-1:0] util_b;
        logic [RUNQ_W-1:0] runnable_avg;
        logic [CNT_W-1:0]  online_count;
    } t_item;

    // Outcome of the load tests on one tick
    typedef struct packed {
        logic down_hit;
        logic up_hit;
    } t_eval;

    // One result word
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             limits_changed;
        logic [CNT_W-1:0] cpu_limit_max;
        logic [CNT_W-1:0] cpu_limit_min;
    } t_result;

    // Threshold register set
    typedef struct packed {
        logic [FREQ_W-1:0] up_freq;
        logic [FREQ_W-1:0] dn_freq;
        logic [UTIL_W-1:0] load;
    } t_cfg;

endpackage
`default_nettype wire

// ===== src/chp_in_if.sv =====
// Input channel of the CPU hotplug policy block.
`default_nettype none
interface chp_in_if;
    logic                         valid;
    logic                         ready;
    logic [chp_pkg::MODE_W-1:0]   mode;
    logic [chp_pkg::FREQ_W-1:0]   freq_a;
    logic [chp_pkg::FREQ_W-1:0]   freq_b;
    logic [chp_pkg::UTIL_W-1:0]   util_a;
    logic [chp_pkg::UTIL_W-1:0]   util_b;
    logic [chp_pkg::RUNQ_W-1:0]   runnable_avg;
    logic [chp_pkg::CNT_W-1:0]    online_count;

    modport source (
        output valid, mode, freq_a, freq_b, util_a, util_b, runnable_avg, online_count,
        input  ready
    );
    modport sink (
        input  valid, mode, freq_a, freq_b, util_a, util_b, runnable_avg, online_count,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/chp_out_if.sv =====
// Result channel of the CPU hotplug policy block.
`default_nettype none
interface chp_out_if;
    logic                       valid;
    logic                       ready;
    logic [chp_pkg::ACT_W-1:0]  action;
    logic                       limits_changed;
    logic [chp_pkg::CNT_W-1:0]  cpu_limit_max;
    logic [chp_pkg::CNT_W-1:0]  cpu_limit_min;

    modport source (
        output valid, action, limits_changed, cpu_limit_max, cpu_limit_min,
        input  ready
    );
    modport sink (
        input  valid, action, limits_changed, cpu_limit_max, cpu_limit_min,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/chp_eval.sv =====
// Cluster ordering and the weighted-load down and up tests.
`default_nettype none
module chp_eval (
    input  var chp_pkg::t_item i_item,
    input  var chp_pkg::t_cfg  i_cfg,
    output var chp_pkg::t_eval o_eval
);
    logic                          swap;
    logic [chp_pkg::FREQ_W-1:0]    f_hi;
    logic [chp_pkg::FREQ_W-1:0]    f_lo;
    logic [chp_pkg::UTIL_W-1:0]    u_hi;
    logic [chp_pkg::UTIL_W-1:0]    u_lo;
    logic [chp_pkg::PROD_W-1:0]    weighted;
    logic [chp_pkg::PROD_W-1:0]    bound_p;
    logic [chp_pkg::PROD_W-1:0]    bound_q;
    logic [chp_pkg::PROD_W-1:0]    bound;

    // faster cluster first
    assign swap = i_item.freq_b > i_item.freq_a;
    assign f_hi = swap ? i_item.freq_b : i_item.freq_a;
    assign f_lo = swap ? i_item.freq_a : i_item.freq_b;
    assign u_hi = swap ? i_item.util_b : i_item.util_a;
    assign u_lo = swap ? i_item.util_a : i_item.util_b;

    // sums and the times-three wrap at 32 bits
    assign weighted = chp_pkg::PROD_W'(f_lo) * chp_pkg::PROD_W'(u_lo)
                    + chp_pkg::PROD_W'(f_hi) * chp_pkg::PROD_W'(u_hi);
    assign bound_p  = chp_pkg::PROD_W'(i_cfg.up_freq) * chp_pkg::PROD_W'(i_cfg.load);
    assign bound_q  = bound_p >> 2;
    assign bound    = bound_q + (bound_q << 1);

    assign o_eval.down_hit = (f_lo != '0) && (f_hi < i_cfg.dn_freq) && (weighted <= bound);
    assign o_eval.up_hit   = (f_hi >= i_cfg.up_freq) && (u_hi >= i_cfg.load)
                          && (i_item.runnable_avg >= chp_pkg::TASK_LIMIT);
endmodule
`default_nettype wire

// ===== src/chp_state.sv =====
// Persistence counters, online level moves and requested CPU limits.
`default_nettype none
module chp_state (
    input  var logic                       i_clk,
    input  var logic                       i_rst_n,
    input  var logic                       i_adv,
    input  var logic [chp_pkg::MODE_W-1:0] i_mode,
    input  var logic [chp_pkg::CNT_W-1:0]  i_online,
    input  var chp_pkg::t_eval             i_eval,
    output var chp_pkg::t_result           o_result
);
    logic [chp_pkg::STREAK_W-1:0] r_up_streak;
    logic [chp_pkg::STREAK_W-1:0] r_down_streak;
    logic [chp_pkg::CNT_W-1:0]    r_lim_max;
    logic [chp_pkg::CNT_W-1:0]    r_lim_min;

    logic [chp_pkg::STREAK_W-1:0] n_up_streak;
    logic [chp_pkg::STREAK_W-1:0] n_down_streak;
    logic [chp_pkg::CNT_W-1:0]    n_lim_max;
    logic [chp_pkg::CNT_W-1:0]    n_lim_min;

    logic [chp_pkg::ACT_W-1:0]    action;
    logic                         req;
    logic [chp_pkg::CNT_W-1:0]    want_max;
    logic [chp_pkg::CNT_W-1:0]    want_min;
    logic                         at_all;
    logic                         at_half;
    logic                         chg_max;
    logic                         chg_min;

    localparam logic [chp_pkg::CNT_W-1:0] ALL_CNT  = chp_pkg::CNT_W'(chp_pkg::NUM_CPUS);
    localparam logic [chp_pkg::CNT_W-1:0] HALF_CNT = chp_pkg::CNT_W'(chp_pkg::HALF_CPUS);
    localparam logic [chp_pkg::CNT_W-1:0] BOOT_CNT = chp_pkg::CNT_W'(chp_pkg::BOOT_MIN_CPUS);

    function automatic logic [chp_pkg::STREAK_W-1:0] bump(
        input logic [chp_pkg::STREAK_W-1:0] c
    );
        return (c < chp_pkg::STREAK_MAX) ? c + 1'b1 : chp_pkg::STREAK_MAX;
    endfunction

    assign at_all  = i_online == ALL_CNT;
    assign at_half = i_online == HALF_CNT;

    always_comb begin
        n_up_streak   = r_up_streak;
        n_down_streak = r_down_streak;
        action        = chp_pkg::ACT_STAY;
        req           = 1'b0;
        want_max      = ALL_CNT;
        want_min      = HALF_CNT;
        case (i_mode)
            chp_pkg::MODE_TICK: begin
                if (i_eval.down_hit) begin
                    n_down_streak = bump(r_down_streak);
                    n_up_streak   = '0;
                end else if (i_eval.up_hit) begin
                    n_up_streak   = bump(r_up_streak);
                    n_down_streak = '0;
                end else begin
                    n_up_streak   = '0;
                    n_down_streak = '0;
                end
                if (n_up_streak > chp_pkg::UP_PERSIST) begin
                    action = chp_pkg::ACT_UP;
                end else if (n_down_streak > chp_pkg::DOWN_PERSIST) begin
                    action = chp_pkg::ACT_DOWN;
                end
                if (action == chp_pkg::ACT_UP) begin
                    // half goes to all, an unknown level goes to half
                    req      = !at_all;
                    want_min = at_half ? ALL_CNT : HALF_CNT;
                end else if (action == chp_pkg::ACT_DOWN) begin
                    // all or an unknown level goes to half
                    req      = !at_half;
                    want_min = HALF_CNT;
                end
                if (action != chp_pkg::ACT_STAY) begin
                    n_up_streak   = '0;
                    n_down_streak = '0;
                end
            end
            chp_pkg::MODE_SUSPEND: begin
                n_up_streak   = '0;
                n_down_streak = '0;
                req           = 1'b1;
                want_max      = HALF_CNT;
                want_min      = HALF_CNT;
            end
            chp_pkg::MODE_RESUME: begin
                req      = 1'b1;
                want_max = ALL_CNT;
                want_min = HALF_CNT;
            end
            default: begin
                req = 1'b0;
            end
        endcase
    end

    // write only limits that differ
    assign chg_max   = req && (want_max != '0) && (want_max != r_lim_max);
    assign chg_min   = req && (want_min != '0) && (want_min != r_lim_min);
    assign n_lim_max = chg_max ? want_max : r_lim_max;
    assign n_lim_min = chg_min ? want_min : r_lim_min;

    assign o_result.action         = action;
    assign o_result.limits_changed = chg_max | chg_min;
    assign o_result.cpu_limit_max  = n_lim_max;
    assign o_result.cpu_limit_min  = n_lim_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_streak   <= '0;
            r_down_streak <= '0;
            r_lim_max     <= ALL_CNT;
            r_lim_min     <= BOOT_CNT;
        end else if (i_adv) begin
            r_up_streak   <= n_up_streak;
            r_down_streak <= n_down_streak;
            r_lim_max     <= n_lim_max;
            r_lim_min     <= n_lim_min;
        end
    end

`ifndef ASSERT_OFF
    a_streak_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up_streak == '0) || (r_down_streak == '0))
        else $error("up and down streaks both nonzero");
    a_action_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (action != chp_pkg::ACT_STAY))
        |=> (r_up_streak == '0) && (r_down_streak == '0))
        else $error("streaks not cleared after an action");
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_up_streak) && $stable(r_down_streak)
                   && $stable(r_lim_max) && $stable(r_lim_min))
        else $error("state moved without an item");
    a_limits_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lim_max != '0) && (r_lim_min != '0))
        else $error("requested limit is zero");
`endif
endmodule
`default_nettype wire

// ===== src/cpu_hotplug_policy.sv =====
// Top level of the CPU hotplug policy block: registers, pipeline and handshakes.
//
//   Channel   Dir   Handshake          Word
//   i_in      in    valid / ready      mode, freq_a/b, util_a/b, runnable_avg, online_count
//   o_out     out   valid / ready      action, limits_changed, cpu_limit_max, cpu_limit_min
//   i_cfg_*   in    write enable only  register index, threshold data
//
// One word per cycle while the result is not stalled; each accepted word passes through
// the input register, then through the load tests and policy update into the
// result register. Policy state advances as a word moves into the result register.
// Reset (i_rst_n low at a clock edge) empties both stages, clears the streaks and
// loads the default thresholds and limits. A stalled result holds in place while the
// input register still accepts one more word.
`default_nettype none
module cpu_hotplug_policy (
    input  var logic                           i_clk,
    input  var logic                           i_rst_n,
    chp_in_if.sink                             i_in,
    chp_out_if.source                          o_out,
    input  var logic                           i_cfg_we,
    input  var logic [chp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  var logic [chp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    chp_pkg::t_cfg    r_cfg;
    chp_pkg::t_item   r_s1;
    logic             r_s1_vld;
    chp_pkg::t_result r_out;
    logic             r_out_vld;

    chp_pkg::t_eval   eval;
    chp_pkg::t_result n_out;
    logic             s2_free;
    logic             s1_adv;
    logic             in_take;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_freq <= chp_pkg::UP_FREQ_RST;
            r_cfg.dn_freq <= chp_pkg::DOWN_FREQ_RST;
            r_cfg.load    <= chp_pkg::LOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                chp_pkg::CFG_UP_FREQ:   r_cfg.up_freq <= i_cfg_data;
                chp_pkg::CFG_DOWN_FREQ: r_cfg.dn_freq <= i_cfg_data;
                chp_pkg::CFG_LOAD:      r_cfg.load    <= i_cfg_data[chp_pkg::UTIL_W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // pipeline flow: result register frees when empty or taken
    assign s2_free    = !r_out_vld || o_out.ready;
    assign s1_adv     = r_s1_vld && s2_free;
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_vld <= i_in.valid;
            end
            if (s2_free) begin
                r_out_vld <= s1_adv;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1.mode         <= i_in.mode;
            r_s1.freq_a       <= i_in.freq_a;
            r_s1.freq_b       <= i_in.freq_b;
            r_s1.util_a       <= i_in.util_a;
            r_s1.util_b       <= i_in.util_b;
            r_s1.runnable_avg <= i_in.runnable_avg;
            r_s1.online_count <= i_in.online_count;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    chp_eval u_eval (
        .i_item (r_s1),
        .i_cfg  (r_cfg),
        .o_eval (eval)
    );

    chp_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (s1_adv),
        .i_mode   (r_s1.mode),
        .i_online (r_s1.online_count),
        .i_eval   (eval),
        .o_result (n_out)
    );

    assign o_out.valid          = r_out_vld;
    assign o_out.action         = r_out.action;
    assign o_out.limits_changed = r_out.limits_changed;
    assign o_out.cpu_limit_max  = r_out.cpu_limit_max;
    assign o_out.cpu_limit_min  = r_out.cpu_limit_min;
endmodule
`default_nettype wire
